@@ sv/clcu_pkg.sv @@
`timescale 1ns / 1ps
package clcu_pkg;

    // operation codes
    localparam logic [2:0] OP_EDGE   = 3'd0;
    localparam logic [2:0] OP_OPEN   = 3'd1;
    localparam logic [2:0] OP_COMMIT = 3'd2;
    localparam logic [2:0] OP_ROLL   = 3'd3;
    localparam logic [2:0] OP_ADD    = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_GRID_EN   = 2'd0;
    localparam logic [1:0] CFG_ROWS_USED = 2'd1;
    localparam logic [1:0] CFG_COLS_USED = 2'd2;

    localparam int COORD_W = 6;
    localparam logic [8:0] CUT_NUM = 9'd393;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]         op;
        logic               neg;
        logic [15:0]        weight;
        logic               placed;
        logic [23:0]        wd_prod;
        logic               cut_ok;
        logic [COORD_W-1:0] row_lo;
        logic [COORD_W-1:0] row_hi;
        logic [COORD_W-1:0] col_lo;
        logic [COORD_W-1:0] col_hi;
        logic [31:0]        cost_term;
    } cmd_t;

    // back end status seen by the top level
    typedef struct packed {
        logic sp_open;
        logic log_empty;
        logic log_over;
    } status_t;

    // 64-bit saturating add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            sat_add64 = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else
            sat_add64 = s;
    endfunction

    // clamp 33-bit load sum to the 32-bit signed range
    function automatic logic signed [31:0] sat_load(input logic signed [32:0] v);
        if (v[32] != v[31])
            sat_load = v[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        else
            sat_load = v[31:0];
    endfunction

endpackage

@@ sv/clcu_front.sv @@
`timescale 1ns / 1ps
module clcu_front (
    input  logic [2:0]         operation,
    input  logic               remove,
    input  logic [15:0]        edge_weight,
    input  logic               endpoints_placed,
    input  logic [7:0]         distance,
    input  logic signed [6:0]  src_row,
    input  logic signed [6:0]  src_col,
    input  logic signed [6:0]  dst_row,
    input  logic signed [6:0]  dst_col,
    input  logic signed [31:0] cost_term,
    output clcu_pkg::cmd_t     cmd
);
    import clcu_pkg::*;

    logic [COORD_W-1:0] sr;
    logic [COORD_W-1:0] sc;
    logic [COORD_W-1:0] dr;
    logic [COORD_W-1:0] dc;

    assign sr = src_row[COORD_W-1:0];
    assign sc = src_col[COORD_W-1:0];
    assign dr = dst_row[COORD_W-1:0];
    assign dc = dst_col[COORD_W-1:0];

    // classify the request and order the cut ranges
    always_comb
    begin
        cmd.op        = operation;
        cmd.neg       = remove;
        cmd.weight    = edge_weight;
        cmd.placed    = endpoints_placed;
        cmd.wd_prod   = 24'(edge_weight * distance);
        cmd.cut_ok    = !src_row[6] && !src_col[6] && !dst_row[6] && !dst_col[6]
                        && (edge_weight != 16'd0);
        cmd.row_lo    = (sr < dr) ? sr : dr;
        cmd.row_hi    = (sr < dr) ? dr : sr;
        cmd.col_lo    = (sc < dc) ? sc : dc;
        cmd.col_hi    = (sc < dc) ? dc : sc;
        cmd.cost_term = cost_term;
    end

endmodule

@@ sv/clcu_fifo.sv @@
`timescale 1ns / 1ps
module clcu_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  clcu_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output clcu_pkg::cmd_t rd_data
);
    import clcu_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    // two-entry request queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ sv/clcu_back.sv @@
`timescale 1ns / 1ps
module clcu_back #(
    parameter int GRID_SIZE  = 64,
    parameter int UNDO_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  clcu_pkg::cmd_t     cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] total_cost,
    output logic               undo_overflow,
    output clcu_pkg::status_t  status
);
    import clcu_pkg::*;

    localparam int IDXW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int LAW  = $clog2(UNDO_DEPTH);
    localparam int UCW  = $clog2(UNDO_DEPTH + 1);
    localparam int LOGW = 1 + IDXW + 32;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIST  = 4'd1;
    localparam logic [3:0] S_NEXT  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_RND   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_RB_RD = 4'd8;
    localparam logic [3:0] S_RB_WR = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    // configuration
    logic       grid_en_reg;
    logic [6:0] rows_used_reg;
    logic [6:0] cols_used_reg;

    // control and datapath registers
    logic [3:0]          state_reg;
    cmd_t                cur_reg;
    logic signed [63:0]  cost_reg;
    logic signed [63:0]  saved_reg;
    logic                sp_reg;
    logic                ovf_reg;
    logic [UCW-1:0]      cnt_reg;
    logic                is_row_reg;
    logic [COORD_W-1:0]  k_reg;
    logic [COORD_W-1:0]  hi_reg;
    logic [IDXW-1:0]     addr_reg;
    logic signed [17:0]  diff_reg;
    logic signed [32:0]  sum_reg;
    logic signed [50:0]  p_reg;
    logic signed [63:0]  cut_term_reg;
    logic                out_valid_reg;
    logic signed [63:0]  out_cost_reg;
    logic                out_ovf_reg;

    // memories and valid bits
    logic [31:0]         row_mem [GRID_SIZE];
    logic [31:0]         col_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] row_vld_reg;
    logic [GRID_SIZE-1:0] col_vld_reg;
    logic [31:0]         row_q;
    logic [31:0]         col_q;
    logic                row_vq;
    logic                col_vq;
    logic [LOGW-1:0]     log_mem [UNDO_DEPTH];
    logic [LOGW-1:0]     log_q;

    // combinational helpers
    logic signed [31:0]  old_load;
    logic signed [16:0]  delta;
    logic signed [31:0]  new_load;
    logic signed [32:0]  diff_wide;
    logic signed [32:0]  sum_next;
    logic [50:0]         mag;
    logic [59:0]         scaled;
    logic [43:0]         q_round;
    logic signed [63:0]  edge_term;
    logic                k_in_range;
    logic                load_we;
    logic                load_row;
    logic [IDXW-1:0]     load_addr;
    logic [31:0]         load_data;
    logic                log_we;
    logic                clear_now;
    logic                fin_take;

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign clear_now = cmd_pop && (cmd.op == OP_CLEAR);
    assign fin_take  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign out_valid     = out_valid_reg;
    assign total_cost    = out_cost_reg;
    assign undo_overflow = out_ovf_reg;

    assign status.sp_open   = sp_reg;
    assign status.log_empty = (cnt_reg == UCW'(0));
    assign status.log_over  = (cnt_reg > UCW'(UNDO_DEPTH));

    // cut update arithmetic
    always_comb
    begin
        old_load  = is_row_reg ? (row_vq ? row_q : 32'd0) : (col_vq ? col_q : 32'd0);
        delta     = cur_reg.neg ? -$signed({1'b0, cur_reg.weight})
                                : $signed({1'b0, cur_reg.weight});
        new_load  = sat_load({old_load[31], old_load} + {{16{delta[16]}}, delta});
        diff_wide = {new_load[31], new_load} - {old_load[31], old_load};
        sum_next  = {new_load[31], new_load} + {old_load[31], old_load};
        mag       = p_reg[50] ? 51'(-p_reg) : 51'(p_reg);
        scaled    = 60'(mag) * 60'(CUT_NUM) + 60'd32768;
        q_round   = scaled[59:16];
        edge_term = cur_reg.neg ? -$signed({32'b0, cur_reg.wd_prod, 8'b0})
                                : $signed({32'b0, cur_reg.wd_prod, 8'b0});
        k_in_range = ({1'b0, k_reg} < (is_row_reg ? rows_used_reg : cols_used_reg))
                     && (32'(k_reg) < GRID_SIZE);
    end

    // load and log write port selection
    always_comb
    begin
        load_we   = 1'b0;
        load_row  = is_row_reg;
        load_addr = addr_reg;
        load_data = new_load;
        if (state_reg == S_UPD)
            load_we = 1'b1;
        else if (state_reg == S_RB_WR)
        begin
            load_we   = 1'b1;
            load_row  = log_q[LOGW-1];
            load_addr = log_q[LOGW-2:32];
            load_data = log_q[31:0];
        end
        log_we = (state_reg == S_UPD) && sp_reg && (cnt_reg < UCW'(UNDO_DEPTH));
    end

    // load memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            row_q <= row_mem[addr_reg];
            col_q <= col_mem[addr_reg];
        end
        if (load_we && load_row)
            row_mem[load_addr] <= load_data;
        if (load_we && !load_row)
            col_mem[load_addr] <= load_data;
    end

    // undo log memory
    always_ff @(posedge clk)
    begin
        if (log_we)
            log_mem[LAW'(cnt_reg)] <= {is_row_reg, addr_reg, old_load};
        if (state_reg == S_RB_RD && cnt_reg != UCW'(0))
            log_q <= log_mem[LAW'(cnt_reg - UCW'(1))];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            col_vld_reg <= '0;
            row_vq      <= 1'b0;
            col_vq      <= 1'b0;
        end
        else
        begin
            if (state_reg == S_RD)
            begin
                row_vq <= row_vld_reg[addr_reg];
                col_vq <= col_vld_reg[addr_reg];
            end
            if (clear_now)
            begin
                row_vld_reg <= '0;
                col_vld_reg <= '0;
            end
            else if (load_we && load_row)
                row_vld_reg[load_addr] <= 1'b1;
            else if (load_we)
                col_vld_reg[load_addr] <= 1'b1;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_en_reg   <= 1'b0;
            rows_used_reg <= 7'd64;
            cols_used_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_EN:   grid_en_reg   <= cfg_wdata[0];
                CFG_ROWS_USED: rows_used_reg <= cfg_wdata;
                CFG_COLS_USED: cols_used_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cur_reg <= cmd;
        if (state_reg == S_NEXT)
            addr_reg <= IDXW'(k_reg);
        if (state_reg == S_UPD)
        begin
            diff_reg <= diff_wide[17:0];
            sum_reg  <= sum_next;
        end
        if (state_reg == S_MUL)
            p_reg <= 51'(diff_reg * sum_reg);
        if (state_reg == S_RND)
            cut_term_reg <= p_reg[50] ? -$signed({20'b0, q_round})
                                      : $signed({20'b0, q_round});
        if (fin_take)
        begin
            out_cost_reg <= cost_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cost_reg      <= '0;
            saved_reg     <= '0;
            sp_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            is_row_reg    <= 1'b1;
            k_reg         <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !fin_take)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_FIN;
                        case (cmd.op)
                            OP_EDGE:
                            begin
                                if (cmd.placed)
                                    state_reg <= S_DIST;
                            end
                            OP_OPEN:
                            begin
                                sp_reg    <= 1'b1;
                                saved_reg <= cost_reg;
                                cnt_reg   <= '0;
                                ovf_reg   <= 1'b0;
                            end
                            OP_COMMIT:
                            begin
                                if (sp_reg)
                                begin
                                    sp_reg  <= 1'b0;
                                    cnt_reg <= '0;
                                end
                            end
                            OP_ROLL:
                            begin
                                if (sp_reg)
                                    state_reg <= S_RB_RD;
                            end
                            OP_ADD:
                                cost_reg <= sat_add64(cost_reg,
                                    {{32{cmd.cost_term[31]}}, cmd.cost_term});
                            OP_CLEAR:
                            begin
                                cost_reg  <= '0;
                                saved_reg <= '0;
                                cnt_reg   <= '0;
                                sp_reg    <= 1'b0;
                                ovf_reg   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIST:
                begin
                    cost_reg <= sat_add64(cost_reg, edge_term);
                    if (grid_en_reg && cur_reg.cut_ok)
                    begin
                        is_row_reg <= 1'b1;
                        k_reg      <= cur_reg.row_lo;
                        hi_reg     <= cur_reg.row_hi;
                        state_reg  <= S_NEXT;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_NEXT:
                begin
                    if (k_reg < hi_reg)
                    begin
                        if (k_in_range)
                            state_reg <= S_RD;
                        else
                            k_reg <= k_reg + COORD_W'(1);
                    end
                    else if (is_row_reg)
                    begin
                        is_row_reg <= 1'b0;
                        k_reg      <= cur_reg.col_lo;
                        hi_reg     <= cur_reg.col_hi;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_RD:
                    state_reg <= S_UPD;
                S_UPD:
                begin
                    if (sp_reg)
                    begin
                        if (cnt_reg < UCW'(UNDO_DEPTH))
                            cnt_reg <= cnt_reg + UCW'(1);
                        else
                            ovf_reg <= 1'b1;
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_RND;
                S_RND:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    cost_reg  <= sat_add64(cost_reg, cut_term_reg);
                    k_reg     <= k_reg + COORD_W'(1);
                    state_reg <= S_NEXT;
                end
                S_RB_RD:
                begin
                    if (cnt_reg == UCW'(0))
                    begin
                        cost_reg  <= saved_reg;
                        sp_reg    <= 1'b0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - UCW'(1);
                        state_reg <= S_RB_WR;
                    end
                end
                S_RB_WR:
                    state_reg <= S_RB_RD;
                S_FIN:
                begin
                    if (fin_take)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/cut_load_cost_with_undo_top.sv @@
`timescale 1ns / 1ps
// Incremental placement cost tracker with one savepoint level. Requests are
// classified at the input and wait in a two-entry queue, so a new request is
// taken while the back end works and while a result waits in the output
// register. The back end sequencer works on one request at a time: an edge
// adds its distance term and, when the grid is enabled and the request
// qualifies for cut terms, walks the touched row cuts and then the column
// cuts, skipping those past the used limit; a rollback restores each logged
// load, newest first, and then the saved cost. Loads live in single-port
// memories with reset-cleared valid bits, so no clearing pass follows reset
// or clear.
module cut_load_cost_with_undo_top #(
    parameter int GRID_SIZE  = 64,
    parameter int UNDO_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic               remove,
    input  logic [15:0]        edge_weight,
    input  logic               endpoints_placed,
    input  logic [7:0]         distance,
    input  logic signed [6:0]  src_row,
    input  logic signed [6:0]  src_col,
    input  logic signed [6:0]  dst_row,
    input  logic signed [6:0]  dst_col,
    input  logic signed [31:0] cost_term,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] total_cost,
    output logic               undo_overflow,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_wdata
);
    import clcu_pkg::*;

    cmd_t    front_cmd;
    cmd_t    q_cmd;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    status_t st;

    assign in_ready = !q_full;

    // request classification
    clcu_front u_front (
        .operation        (operation),
        .remove           (remove),
        .edge_weight      (edge_weight),
        .endpoints_placed (endpoints_placed),
        .distance         (distance),
        .src_row          (src_row),
        .src_col          (src_col),
        .dst_row          (dst_row),
        .dst_col          (dst_col),
        .cost_term        (cost_term),
        .cmd              (front_cmd)
    );

    // queue between front and back
    clcu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .wr_data   (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_data   (q_cmd)
    );

    // execution sequencer
    clcu_back #(
        .GRID_SIZE  (GRID_SIZE),
        .UNDO_DEPTH (UNDO_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (q_cmd),
        .cmd_valid     (q_valid),
        .cmd_pop       (q_pop),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .total_cost    (total_cost),
        .undo_overflow (undo_overflow),
        .status        (st)
    );

    // undo log count never passes its depth
    a_log_bound: assert property (@(posedge clk) disable iff (!rst_n) !st.log_over)
        else $error("undo count beyond log depth");

    // no savepoint means an empty log
    a_log_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !st.sp_open |-> st.log_empty)
        else $error("undo log not empty with no savepoint open");

    // queue never pops when empty
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request popped from empty queue");

endmodule
